// File: hdl/euler_scale_transform_matrix_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef EULER_SCALE_TRANSFORM_MATRIX_TOP_MACROS_SVH
`define EULER_SCALE_TRANSFORM_MATRIX_TOP_MACROS_SVH

// Checked only while out of reset.
`define ESM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define ESM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hdl/esm_pkg.sv
// ----------------------------------------------------------------------------
// esm_pkg
// Types, constants and arithmetic helpers for the Euler rotation/scale matrix.
// ----------------------------------------------------------------------------
`default_nettype none

package esm_pkg;

    localparam int ITERS        = 20;
    localparam int TW           = 32;   // Q1.30 trig and product width
    localparam int ZW           = 25;   // angle accumulator, degrees * 65536
    localparam int CORDIC_LAT   = ITERS + 2;
    localparam int TOTAL_LAT    = CORDIC_LAT + 5;

    localparam logic signed [TW-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [16:0] TURN          = 17'sd23040;
    localparam logic signed [16:0] HALF_TURN     = 17'sd11520;
    localparam logic signed [16:0] QUARTER_TURN  = 17'sd5760;
    localparam logic signed [26:0] OUT_MAX       = 27'sd8388607;
    localparam logic signed [26:0] OUT_MIN       = -27'sd8388608;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] scale_z;
    } esm_in_t;

    typedef struct packed {
        logic signed [23:0] m_r0_c0;
        logic signed [23:0] m_r0_c1;
        logic signed [23:0] m_r0_c2;
        logic signed [23:0] m_r1_c0;
        logic signed [23:0] m_r1_c1;
        logic signed [23:0] m_r1_c2;
        logic signed [23:0] m_r2_c0;
        logic signed [23:0] m_r2_c1;
        logic signed [23:0] m_r2_c2;
    } esm_out_t;

    // atan(2^-i) in degrees * 65536
    function automatic logic signed [ZW-1:0] atan_lut(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 25'sd2949120;
            1:  v = 25'sd1740967;
            2:  v = 25'sd919879;
            3:  v = 25'sd466945;
            4:  v = 25'sd234379;
            5:  v = 25'sd117304;
            6:  v = 25'sd58666;
            7:  v = 25'sd29335;
            8:  v = 25'sd14668;
            9:  v = 25'sd7334;
            10: v = 25'sd3667;
            11: v = 25'sd1833;
            12: v = 25'sd917;
            13: v = 25'sd458;
            14: v = 25'sd229;
            15: v = 25'sd115;
            16: v = 25'sd57;
            17: v = 25'sd29;
            18: v = 25'sd14;
            19: v = 25'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/esm_cordic.sv
// ----------------------------------------------------------------------------
// esm_cordic
// Pipelined degree-domain CORDIC: wraps the angle to one turn, folds it into
// +-90 degrees, then one rotation per stage; yields Q1.30 sine and cosine.
// ----------------------------------------------------------------------------
`default_nettype none

module esm_cordic (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic signed [15:0]                angle,
    output logic signed [esm_pkg::TW-1:0]          sin_o,
    output logic signed [esm_pkg::TW-1:0]          cos_o
);
    import esm_pkg::*;

    logic signed [TW-1:0] x_reg [0:ITERS];
    logic signed [TW-1:0] y_reg [0:ITERS];
    logic signed [ZW-1:0] z_reg [0:ITERS];
    logic                 negc_reg [0:ITERS];

    logic signed [16:0]   a_ext;
    logic signed [16:0]   r_wrap;
    logic signed [16:0]   r_fold;
    logic                 negc_next;
    logic signed [ZW-1:0] z_next;

    // wrap into [-half, half) then fold into a quarter turn
    always_comb begin
        a_ext = {angle[15], angle};
        if (a_ext >= HALF_TURN) begin
            r_wrap = a_ext - TURN;
        end else if (a_ext < -HALF_TURN) begin
            r_wrap = a_ext + TURN;
        end else begin
            r_wrap = a_ext;
        end
        negc_next = 1'b0;
        r_fold    = r_wrap;
        if (r_wrap > QUARTER_TURN) begin
            r_fold    = HALF_TURN - r_wrap;
            negc_next = 1'b1;
        end else if (r_wrap < -QUARTER_TURN) begin
            r_fold    = -HALF_TURN - r_wrap;
            negc_next = 1'b1;
        end
        z_next = ZW'(r_fold) <<< 10;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_next;
            negc_reg[0] <= negc_next;
        end
    end

    for (genvar i = 0; i < ITERS; i++) begin : g_iter
        logic signed [TW-1:0] dx;
        logic signed [TW-1:0] dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][ZW-1]) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_lut(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_lut(i);
                end
                negc_reg[i+1] <= negc_reg[i];
            end
        end
    end

    logic signed [TW-1:0] sin_reg;
    logic signed [TW-1:0] cos_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= y_reg[ITERS];
            cos_reg <= negc_reg[ITERS] ? -x_reg[ITERS] : x_reg[ITERS];
        end
    end

    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

`default_nettype wire

// File: hdl/euler_scale_transform_matrix_top.sv
// ----------------------------------------------------------------------------
// euler_scale_transform_matrix_top
// Builds Rx*Ry*Rz*diag(sx,sy,sz) in Q7.16 from Q9.6 degree angles and Q7.8
// scales: three CORDICs, then pair products, triple products, sums, scaling
// and saturation.
// ----------------------------------------------------------------------------
//  channel   direction   payload     handshake
//  s_        in          esm_in_t    s_valid / s_ready
//  m_        out         esm_out_t   m_valid / m_ready
//
//  One request enters per cycle unless the pipe holds; it has 1 wrap/fold
//  stage, 20 CORDIC stages, 1 cosine sign stage, 5 product and saturation
//  stages. Reset clears only the stage valid bits.
//  The whole pipe advances together; it holds while a result sits on m_ and
//  m_ready is low, and bubbles inside it hold as well.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_scale_transform_matrix_top (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire esm_pkg::esm_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output esm_pkg::esm_out_t      m_data
);
    import esm_pkg::*;
    `include "euler_scale_transform_matrix_top_macros.svh"

    function automatic logic signed [TW-1:0] mul30(input logic signed [TW-1:0] a,
                                                   input logic signed [TW-1:0] b);
        logic signed [2*TW-1:0] p;
        p = a * b + (64'sd1 <<< 29);
        return p[TW+29:30];
    endfunction

    function automatic logic signed [TW:0] ext(input logic signed [TW-1:0] a);
        return {a[TW-1], a};
    endfunction

    function automatic logic signed [23:0] sat(input logic signed [48:0] p);
        logic signed [48:0] r;
        logic signed [26:0] v;
        r = p + (49'sd1 <<< 21);
        v = r[48:22];
        if (v > OUT_MAX) begin
            v = OUT_MAX;
        end else if (v < OUT_MIN) begin
            v = OUT_MIN;
        end
        return v[23:0];
    endfunction

    logic en;
    logic [TOTAL_LAT-1:0] vld_reg;
    logic [TOTAL_LAT-1:0] vld_next;

    assign en      = m_ready || !vld_reg[TOTAL_LAT-1];
    assign s_ready = en;
    assign m_valid = vld_reg[TOTAL_LAT-1];

    always_comb begin
        vld_next = vld_reg;
        if (en) begin
            vld_next = {vld_reg[TOTAL_LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // trig units
    logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;

    esm_cordic u_cordic_x (.aclk(aclk), .en(en), .angle(s_data.angle_x), .sin_o(sx), .cos_o(cx));
    esm_cordic u_cordic_y (.aclk(aclk), .en(en), .angle(s_data.angle_y), .sin_o(sy), .cos_o(cy));
    esm_cordic u_cordic_z (.aclk(aclk), .en(en), .angle(s_data.angle_z), .sin_o(sz), .cos_o(cz));

    // scales ride alongside the CORDIC stages
    logic signed [15:0] scx_reg [0:CORDIC_LAT-1];
    logic signed [15:0] scy_reg [0:CORDIC_LAT-1];
    logic signed [15:0] scz_reg [0:CORDIC_LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            scx_reg[0] <= s_data.scale_x;
            scy_reg[0] <= s_data.scale_y;
            scz_reg[0] <= s_data.scale_z;
            for (int i = 1; i < CORDIC_LAT; i++) begin
                scx_reg[i] <= scx_reg[i-1];
                scy_reg[i] <= scy_reg[i-1];
                scz_reg[i] <= scz_reg[i-1];
            end
        end
    end

    // pair products
    logic signed [TW-1:0] cycz_reg, cysz_reg, sxsy_reg, cxsy_reg, cxsz_reg;
    logic signed [TW-1:0] cxcz_reg, sxcy_reg, sxsz_reg, sxcz_reg, cxcy_reg;
    logic signed [TW-1:0] sy1_reg, cz1_reg, sz1_reg;
    logic signed [15:0]   sc1_reg [0:2];

    always_ff @(posedge aclk) begin
        if (en) begin
            cycz_reg <= mul30(cy, cz);
            cysz_reg <= mul30(cy, sz);
            sxsy_reg <= mul30(sx, sy);
            cxsy_reg <= mul30(cx, sy);
            cxsz_reg <= mul30(cx, sz);
            cxcz_reg <= mul30(cx, cz);
            sxcy_reg <= mul30(sx, cy);
            sxsz_reg <= mul30(sx, sz);
            sxcz_reg <= mul30(sx, cz);
            cxcy_reg <= mul30(cx, cy);
            sy1_reg  <= sy;
            cz1_reg  <= cz;
            sz1_reg  <= sz;
            sc1_reg[0] <= scx_reg[CORDIC_LAT-1];
            sc1_reg[1] <= scy_reg[CORDIC_LAT-1];
            sc1_reg[2] <= scz_reg[CORDIC_LAT-1];
        end
    end

    // triple products
    logic signed [TW-1:0] ta_reg, tb_reg, tc_reg, td_reg;
    logic signed [TW-1:0] cycz2_reg, cysz2_reg, cxsz2_reg, cxcz2_reg, sxcy2_reg;
    logic signed [TW-1:0] sxsz2_reg, sxcz2_reg, cxcy2_reg, sy2_reg;
    logic signed [15:0]   sc2_reg [0:2];

    always_ff @(posedge aclk) begin
        if (en) begin
            ta_reg    <= mul30(sxsy_reg, cz1_reg);
            tb_reg    <= mul30(sxsy_reg, sz1_reg);
            tc_reg    <= mul30(cxsy_reg, cz1_reg);
            td_reg    <= mul30(cxsy_reg, sz1_reg);
            cycz2_reg <= cycz_reg;
            cysz2_reg <= cysz_reg;
            cxsz2_reg <= cxsz_reg;
            cxcz2_reg <= cxcz_reg;
            sxcy2_reg <= sxcy_reg;
            sxsz2_reg <= sxsz_reg;
            sxcz2_reg <= sxcz_reg;
            cxcy2_reg <= cxcy_reg;
            sy2_reg   <= sy1_reg;
            sc2_reg   <= sc1_reg;
        end
    end

    // matrix entries, Q1.30 with one guard bit
    logic signed [TW:0]  m_reg [0:8];
    logic signed [15:0]  sc3_reg [0:2];

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0] <= ext(cycz2_reg);
            m_reg[1] <= -ext(cysz2_reg);
            m_reg[2] <= ext(sy2_reg);
            m_reg[3] <= ext(ta_reg) + ext(cxsz2_reg);
            m_reg[4] <= ext(cxcz2_reg) - ext(tb_reg);
            m_reg[5] <= -ext(sxcy2_reg);
            m_reg[6] <= ext(sxsz2_reg) - ext(tc_reg);
            m_reg[7] <= ext(td_reg) + ext(sxcz2_reg);
            m_reg[8] <= ext(cxcy2_reg);
            sc3_reg  <= sc2_reg;
        end
    end

    // scale each column
    logic signed [48:0] p_reg [0:8];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                p_reg[k] <= m_reg[k] * sc3_reg[k % 3];
            end
        end
    end

    // round and saturate into the output register
    esm_out_t out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.m_r0_c0 <= sat(p_reg[0]);
            out_reg.m_r0_c1 <= sat(p_reg[1]);
            out_reg.m_r0_c2 <= sat(p_reg[2]);
            out_reg.m_r1_c0 <= sat(p_reg[3]);
            out_reg.m_r1_c1 <= sat(p_reg[4]);
            out_reg.m_r1_c2 <= sat(p_reg[5]);
            out_reg.m_r2_c0 <= sat(p_reg[6]);
            out_reg.m_r2_c1 <= sat(p_reg[7]);
            out_reg.m_r2_c2 <= sat(p_reg[8]);
        end
    end

    assign m_data = out_reg;

    `ESM_ASSERT_ALWAYS(a_reset_clears, $past(!aresetn) |-> !m_valid, "result valid after reset")
    `ESM_ASSERT(a_stall_backs_up, (m_valid && !m_ready) |-> !s_ready, "request taken while output stalled")
    `ESM_ASSERT(a_drain_empty, (m_valid && m_ready && !vld_reg[TOTAL_LAT-2]) |=> !m_valid, "result repeated after drain")

endmodule

`default_nettype wire
